[design/vabs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vabs_pkg;

  // Angles inside the first quadrant run from 0 to 90 degrees.
  localparam int unsigned SineEntries = 91;
  typedef logic [6:0] ang_t;
  localparam ang_t AngLow = 7'd0;
  localparam ang_t AngTop = 7'd90;

  // Folded angle and offsets, in degrees.
  typedef logic [8:0] deg_t;
  localparam deg_t DegHalf = 9'd180;
  localparam deg_t DegFull = 9'd360;
  localparam logic signed [31:0] DegOffset = 32'sd90;

  // Magnitude of a coordinate difference and its squares.
  localparam int unsigned MagW  = 16;
  localparam int unsigned Dy2W  = 32;
  localparam int unsigned Len2W = 33;

  localparam int unsigned MicroScale = 1000000;
  localparam int unsigned MicroHalf  = 500000;

  // Sine of k degrees, in millionths.
  localparam logic [19:0] SineMicro [SineEntries] = '{
    20'd0,      20'd17452,  20'd34899,  20'd52336,  20'd69756,  20'd87156,
    20'd104528, 20'd121869, 20'd139173, 20'd156434, 20'd173648, 20'd190809,
    20'd207912, 20'd224951, 20'd241922, 20'd258819, 20'd275637, 20'd292372,
    20'd309017, 20'd325568, 20'd342020, 20'd358368, 20'd374607, 20'd390731,
    20'd406737, 20'd422618, 20'd438371, 20'd453990, 20'd469472, 20'd484810,
    20'd500000, 20'd515038, 20'd529919, 20'd544639, 20'd559193, 20'd573576,
    20'd587785, 20'd601815, 20'd615661, 20'd629320, 20'd642788, 20'd656059,
    20'd669131, 20'd681998, 20'd694658, 20'd707107, 20'd719340, 20'd731354,
    20'd743145, 20'd754710, 20'd766044, 20'd777146, 20'd788011, 20'd798636,
    20'd809017, 20'd819152, 20'd829038, 20'd838671, 20'd848048, 20'd857167,
    20'd866025, 20'd874620, 20'd882948, 20'd891007, 20'd898794, 20'd906308,
    20'd913545, 20'd920505, 20'd927184, 20'd933580, 20'd939693, 20'd945519,
    20'd951057, 20'd956305, 20'd961262, 20'd965926, 20'd970296, 20'd974370,
    20'd978148, 20'd981627, 20'd984808, 20'd987688, 20'd990268, 20'd992546,
    20'd994522, 20'd996195, 20'd997564, 20'd998630, 20'd999391, 20'd999848,
    20'd1000000
  };

  // Fixed-point sine with frac fraction bits, rounded half up. Only used to
  // build constant tables during elaboration.
  function automatic logic [63:0] sine_fixed(int unsigned k, int unsigned frac);
    logic [63:0] m;
    m = 64'(SineMicro[k]);
    return ((m << frac) + 64'(MicroHalf)) / 64'(MicroScale);
  endfunction

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [31:0] previous_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               zero_vector;
  } out_word_t;

  // Per-word data carried down the search chain.
  typedef struct packed {
    logic             zero;
    logic             dx_neg;
    logic             dy_neg;
    logic [31:0]      prev;
    logic [Dy2W-1:0]  dy2;
    logic [Len2W-1:0] len2;
  } vec_t;

  // Bracket of table entries still in play.
  typedef struct packed {
    ang_t lo;
    ang_t hi;
  } span_t;

endpackage

`default_nettype wire

[design/vabs_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface vabs_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/vabs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module vabs_front import vabs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output vec_t          vec_o,
  output span_t         span_o
);

  logic signed [16:0] dx, dy;
  logic [MagW-1:0]    adx, ady;
  logic [Dy2W-1:0]    dx2, dy2;
  vec_t               vec_d, vec_q;
  logic               valid_q;

  always_comb begin
    dx  = 17'(in_word_i.end_x) - 17'(in_word_i.start_x);
    dy  = 17'(in_word_i.end_y) - 17'(in_word_i.start_y);
    adx = dx[16] ? MagW'(-dx) : MagW'(dx);
    ady = dy[16] ? MagW'(-dy) : MagW'(dy);
    dx2 = Dy2W'(adx) * Dy2W'(adx);
    dy2 = Dy2W'(ady) * Dy2W'(ady);

    vec_d.zero   = (dx == 17'sd0) && (dy == 17'sd0);
    vec_d.dx_neg = dx[16];
    vec_d.dy_neg = dy[16];
    vec_d.prev   = in_word_i.previous_value;
    vec_d.dy2    = dy2;
    vec_d.len2   = Len2W'(dx2) + Len2W'(dy2);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign vec_o       = vec_q;
  assign span_o      = '{lo: AngLow, hi: AngTop};

endmodule

`default_nettype wire

[design/vabs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module vabs_cell import vabs_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire vec_t  vec_i,
  input  wire span_t span_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output vec_t       vec_o,
  output span_t      span_o
);

  localparam int unsigned T2W = 2 * SINE_FRAC_BITS + 1;
  localparam int unsigned LoW = (T2W + 1) / 2;
  localparam int unsigned HiW = T2W - LoW;
  localparam int unsigned PLW = LoW + Len2W;
  localparam int unsigned PHW = HiW + Len2W;
  localparam int unsigned PW  = T2W + Len2W;

  typedef logic [SineEntries-1:0][T2W-1:0] t2_tab_t;

  function automatic t2_tab_t build_t2();
    t2_tab_t     tab;
    logic [63:0] t;
    for (int k = 0; k < SineEntries; k++) begin
      t      = sine_fixed(k, SINE_FRAC_BITS);
      tab[k] = T2W'(t * t);
    end
    return tab;
  endfunction

  localparam t2_tab_t T2Tab = build_t2();

  // Stage A: pick the midpoint, look up its squared sine and multiply it by
  // the squared length in two halves.
  ang_t           mid_d, mid_q;
  logic [T2W-1:0] t2;
  logic [PLW-1:0] pl_d, pl_q;
  logic [PHW-1:0] ph_d, ph_q;
  vec_t           vec_a_q;
  span_t          span_a_q;
  logic           valid_a_q, ready_a;

  // Stage B: exact squared test and bracket update.
  logic [PW-1:0]  prod, rhs;
  logic           below;
  span_t          span_d, span_q;
  vec_t           vec_b_q;
  logic           valid_b_q, ready_b;

  always_comb begin
    mid_d = span_i.lo + ((span_i.hi - span_i.lo) >> 1);
    t2    = T2Tab[mid_d];
    pl_d  = PLW'(t2[LoW-1:0]) * PLW'(vec_i.len2);
    ph_d  = PHW'(t2[T2W-1:LoW]) * PHW'(vec_i.len2);
  end

  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (ready_a) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      mid_q    <= mid_d;
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      vec_a_q  <= vec_i;
      span_a_q <= span_i;
    end
  end

  // The midpoint entry lies below the sine when t^2 * len2 < dy2 * 2^(2F).
  always_comb begin
    prod  = PW'(pl_q) + (PW'(ph_q) << LoW);
    rhs   = PW'(vec_a_q.dy2) << (2 * SINE_FRAC_BITS);
    below = prod < rhs;
    if (below) begin
      span_d = '{lo: mid_q, hi: span_a_q.hi};
    end else begin
      span_d = '{lo: span_a_q.lo, hi: mid_q};
    end
  end

  assign ready_b = !valid_b_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (ready_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      span_q  <= span_d;
      vec_b_q <= vec_a_q;
    end
  end

  assign out_valid_o = valid_b_q;
  assign vec_o       = vec_b_q;
  assign span_o      = span_q;

endmodule

`default_nettype wire

[design/vabs_pick.sv]
`timescale 1ns / 1ps
`default_nettype none

module vabs_pick import vabs_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire vec_t  vec_i,
  input  wire span_t span_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_word_t  out_word_o
);

  localparam int unsigned S2W = 2 * SINE_FRAC_BITS + 3;
  localparam int unsigned LoW = (S2W + 1) / 2;
  localparam int unsigned HiW = S2W - LoW;
  localparam int unsigned PLW = LoW + Len2W;
  localparam int unsigned PHW = HiW + Len2W;
  localparam int unsigned PW  = S2W + Len2W;

  typedef logic [SineEntries-1:0][S2W-1:0] s2_tab_t;

  // Squared sum of the bracketing entries, for a bracket one degree wide.
  function automatic s2_tab_t build_next();
    s2_tab_t     tab;
    logic [63:0] s;
    for (int k = 0; k < SineEntries; k++) begin
      if (k + 1 < SineEntries) begin
        s = sine_fixed(k, SINE_FRAC_BITS) + sine_fixed(k + 1, SINE_FRAC_BITS);
      end else begin
        s = 2 * sine_fixed(k, SINE_FRAC_BITS);
      end
      tab[k] = S2W'(s * s);
    end
    return tab;
  endfunction

  // Squared sum for a bracket that has closed onto a single entry.
  function automatic s2_tab_t build_same();
    s2_tab_t     tab;
    logic [63:0] s;
    for (int k = 0; k < SineEntries; k++) begin
      s      = 2 * sine_fixed(k, SINE_FRAC_BITS);
      tab[k] = S2W'(s * s);
    end
    return tab;
  endfunction

  localparam s2_tab_t NextTab = build_next();
  localparam s2_tab_t SameTab = build_same();

  logic [S2W-1:0] s2;
  logic [PLW-1:0] pl_d, pl_q;
  logic [PHW-1:0] ph_d, ph_q;
  vec_t           vec_q;
  span_t          span_q;
  logic           valid_a_q, ready_a;

  logic [PW-1:0]  prod, rhs;
  deg_t           ang, full;
  out_word_t      word_d, word_q;
  logic           valid_b_q, ready_b;

  always_comb begin
    s2   = (span_i.lo == span_i.hi) ? SameTab[span_i.lo] : NextTab[span_i.lo];
    pl_d = PLW'(s2[LoW-1:0]) * PLW'(vec_i.len2);
    ph_d = PHW'(s2[S2W-1:LoW]) * PHW'(vec_i.len2);
  end

  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (ready_a) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      vec_q  <= vec_i;
      span_q <= span_i;
    end
  end

  // The lower entry wins only when 4 * dy2 * 2^(2F) < (t[lo] + t[hi])^2 * len2,
  // so a tie goes to the upper entry.
  always_comb begin
    prod = PW'(pl_q) + (PW'(ph_q) << LoW);
    rhs  = PW'(vec_q.dy2) << (2 * SINE_FRAC_BITS + 2);
    ang  = (rhs < prod) ? deg_t'(span_q.lo) : deg_t'(span_q.hi);

    case ({vec_q.dx_neg, vec_q.dy_neg})
      2'b10:   full = DegHalf - ang;
      2'b11:   full = DegHalf + ang;
      2'b01:   full = DegFull - ang;
      default: full = ang;
    endcase

    if (vec_q.zero) begin
      word_d.result_value = vec_q.prev;
      word_d.zero_vector  = 1'b1;
    end else begin
      word_d.result_value = $signed(32'(full)) - DegOffset;
      word_d.zero_vector  = 1'b0;
    end
  end

  assign ready_b = !valid_b_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (ready_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

[design/vector_angle_by_sine_search.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word       Fields
// in_i      in   in_word_t  start_x, start_y, end_x, end_y, previous_value
// out_o     out  out_word_t result_value, zero_vector
//
// One word is accepted per cycle while the output is not held; each word passes
// through one input stage, two stages per search cell (multiply, then compare),
// and two for the final nearest-entry choice.
// Every stage has its own valid bit, so bubbles close up and a word held at
// the output stalls only the stages that are full behind it.
// Reset clears the valid bits only; no state survives between words.

module vector_angle_by_sine_search import vabs_pkg::*; #(
  parameter int unsigned SEARCH_STEPS   = 7,
  parameter int unsigned SINE_FRAC_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vabs_chan_if.sink   in_i,
  vabs_chan_if.source out_o
);

  logic  valid_s [SEARCH_STEPS+1];
  logic  ready_s [SEARCH_STEPS+1];
  vec_t  vec_s   [SEARCH_STEPS+1];
  span_t span_s  [SEARCH_STEPS+1];

  vabs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_word_i   (in_i.data),
    .out_valid_o (valid_s[0]),
    .out_ready_i (ready_s[0]),
    .vec_o       (vec_s[0]),
    .span_o      (span_s[0])
  );

  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_cell
    vabs_cell #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[i]),
      .in_ready_o  (ready_s[i]),
      .vec_i       (vec_s[i]),
      .span_i      (span_s[i]),
      .out_valid_o (valid_s[i+1]),
      .out_ready_i (ready_s[i+1]),
      .vec_o       (vec_s[i+1]),
      .span_o      (span_s[i+1])
    );
  end

  vabs_pick #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[SEARCH_STEPS]),
    .in_ready_o  (ready_s[SEARCH_STEPS]),
    .vec_i       (vec_s[SEARCH_STEPS]),
    .span_i      (span_s[SEARCH_STEPS]),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.data)
  );

endmodule

`default_nettype wire

[tb/vector_angle_by_sine_search_test.sv]
`timescale 1ns / 1ps

module vector_angle_by_sine_search_test;
  import vabs_pkg::*;

  localparam int unsigned SearchSteps = 7;
  localparam int unsigned FracBits    = 20;
  localparam int unsigned Latency     = 2 * SearchSteps + 3;
  localparam int          CycleLimit  = 300000;
  localparam int          HalfTurn    = 180;
  localparam int          FullTurn    = 360;
  localparam int          AngleOffset = 90;
  localparam int          CoordMax    = 32767;
  localparam int          CoordMin    = -32768;

  // Sine of k degrees in millionths, k = 0..90.
  localparam int unsigned SineMillionths [91] = '{
    0, 17452, 34899, 52336, 69756, 87156, 104528, 121869, 139173, 156434,
    173648, 190809, 207912, 224951, 241922, 258819, 275637, 292372, 309017,
    325568, 342020, 358368, 374607, 390731, 406737, 422618, 438371, 453990,
    469472, 484810, 500000, 515038, 529919, 544639, 559193, 573576, 587785,
    601815, 615661, 629320, 642788, 656059, 669131, 681998, 694658, 707107,
    719340, 731354, 743145, 754710, 766044, 777146, 788011, 798636, 809017,
    819152, 829038, 838671, 848048, 857167, 866025, 874620, 882948, 891007,
    898794, 906308, 913545, 920505, 927184, 933580, 939693, 945519, 951057,
    956305, 961262, 965926, 970296, 974370, 978148, 981627, 984808, 987688,
    990268, 992546, 994522, 996195, 997564, 998630, 999391, 999848, 1000000
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  vabs_chan_if #(.word_t(in_word_t))  in_ch ();
  vabs_chan_if #(.word_t(out_word_t)) out_ch ();

  vector_angle_by_sine_search #(
    .SEARCH_STEPS  (SearchSteps),
    .SINE_FRAC_BITS(FracBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  out_word_t pending_angles[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[vector_angle_by_sine_search] ERROR");
      $finish;
    end
  end

  function automatic logic [127:0] sine_scaled(int k);
    return ((128'(SineMillionths[k]) << FracBits) + 128'd500000) / 128'd1000000;
  endfunction

  // Angle of the difference vector minus 90 degrees, found by a bisection of
  // the sine table with every comparison done exactly on squares.
  function automatic out_word_t predict_angle(in_word_t w);
    logic [16:0]  dx, dy, adx, ady;
    logic [127:0] dy2, len2, tm, tsum, lhs, rhs;
    int           lo, hi, mid, angle;
    out_word_t    r;
    dx = {w.end_x[15], w.end_x} - {w.start_x[15], w.start_x};
    dy = {w.end_y[15], w.end_y} - {w.start_y[15], w.start_y};
    if (dx == '0 && dy == '0) begin
      r.result_value = w.previous_value;
      r.zero_vector  = 1'b1;
      return r;
    end
    adx  = dx[16] ? (~dx + 17'd1) : dx;
    ady  = dy[16] ? (~dy + 17'd1) : dy;
    dy2  = 128'(ady) * 128'(ady);
    len2 = 128'(adx) * 128'(adx) + dy2;
    lo   = 0;
    hi   = 90;
    for (int i = 0; i < SearchSteps; i++) begin
      mid = lo + (hi - lo) / 2;
      tm  = sine_scaled(mid);
      lhs = tm * tm * len2;
      rhs = dy2 << (2 * FracBits);
      if (lhs < rhs) lo = mid;
      else hi = mid;
    end
    // Keep the lower entry only when the sine lies strictly below the
    // midpoint of the bracket; a tie goes to the upper entry.
    tsum  = sine_scaled(lo) + sine_scaled(hi);
    lhs   = (dy2 * 128'd4) << (2 * FracBits);
    rhs   = tsum * tsum * len2;
    angle = (lhs < rhs) ? lo : hi;
    if (dx[16] && !dy[16]) angle = HalfTurn - angle;
    else if (dx[16] && dy[16]) angle = HalfTurn + angle;
    else if (!dx[16] && dy[16]) angle = FullTurn - angle;
    r.result_value = angle - AngleOffset;
    r.zero_vector  = 1'b0;
    return r;
  endfunction

  // Result checking and receiver back-pressure.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected word: result_value %0d, zero_vector %0d",
               out_ch.data.result_value, out_ch.data.zero_vector);
        fail_count++;
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 want.result_value, out_ch.data.result_value);
          fail_count++;
        end
        if (out_ch.data.zero_vector !== want.zero_vector) begin
          $error("zero_vector: expected %0d, got %0d",
                 want.zero_vector, out_ch.data.zero_vector);
          fail_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one word; valid stays high afterwards so back-to-back words need no
  // gap. The expected result is queued once the word is taken.
  task automatic send_points(input logic signed [15:0] sx, input logic signed [15:0] sy,
                             input logic signed [15:0] ex, input logic signed [15:0] ey,
                             input logic signed [31:0] prev);
    in_word_t w;
    w.start_x        = sx;
    w.start_y        = sy;
    w.end_x          = ex;
    w.end_y          = ey;
    w.previous_value = prev;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_angles.push_back(predict_angle(w));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  function automatic int shift_in_range(int s, int d);
    int e;
    e = s + d;
    if (e > CoordMax || e < CoordMin) e = s - d;
    return e;
  endfunction

  task automatic test_zero_vector();
    send_points(0, 0, 0, 0, 32'sh8000_0000);
    send_points(-32768, -32768, -32768, -32768, 32'sh7fff_ffff);
    send_points(32767, 32767, 32767, 32767, 32'sh5a5a_5a5a);
    send_points(1234, -4321, 1234, -4321, -1);
  endtask

  task automatic test_axes_and_diagonals();
    send_points(0, 0, 5, 0, 11);
    send_points(0, 0, -5, 0, 12);
    send_points(0, 0, 0, 7, 13);
    send_points(0, 0, 0, -7, 14);
    send_points(0, 0, 3, 3, 15);
    send_points(0, 0, -3, 3, 16);
    send_points(0, 0, -3, -3, 17);
    send_points(0, 0, 3, -3, 18);
  endtask

  // Coordinate differences that need the full 17 bits, and angles right next
  // to the axes.
  task automatic test_extremes();
    send_points(-32768, 0, 32767, 0, 0);
    send_points(32767, 0, -32768, 0, 0);
    send_points(0, -32768, 0, 32767, 0);
    send_points(0, 32767, 0, -32768, 0);
    send_points(-32768, -32768, 32767, 32767, 0);
    send_points(32767, -32768, -32768, 32767, 0);
    send_points(0, 0, 32767, 1, 0);
    send_points(0, 0, 1, 32767, 0);
    send_points(-32768, 32767, 32767, -32768, 0);
    send_points(32767, 32767, -32768, 32766, 0);
  endtask

  task automatic test_random_points(int count);
    int                 kind, sx, sy, ex, ey, dx, dy, mag;
    logic signed [15:0] r16;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      r16  = 16'($urandom);
      sx   = int'(r16);
      r16  = 16'($urandom);
      sy   = int'(r16);
      if (kind < 6) begin
        ex = sx;
        ey = sy;
      end else if (kind < 35) begin
        dx = $urandom_range(8) - 4;
        dy = $urandom_range(8) - 4;
        ex = shift_in_range(sx, dx);
        ey = shift_in_range(sy, dy);
      end else if (kind < 50) begin
        mag = $urandom_range(30000, 1);
        case ($urandom_range(2))
          0: begin
            dx = mag;
            dy = 0;
          end
          1: begin
            dx = 0;
            dy = mag;
          end
          default: begin
            dx = mag;
            dy = mag;
          end
        endcase
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
        ex = shift_in_range(sx, dx);
        ey = shift_in_range(sy, dy);
      end else begin
        r16 = 16'($urandom);
        ex  = int'(r16);
        r16 = 16'($urandom);
        ey  = int'(r16);
      end
      send_points(16'(sx), 16'(sy), 16'(ex), 16'(ey), $urandom);
      if (n == count / 2) wait_for_results();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 74;
    test_zero_vector();
    test_axes_and_diagonals();
    test_extremes();
    test_random_points(220);
    wait_for_results();

    send_idle_pct = 74;
    recv_idle_pct = 21;
    test_random_points(220);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_points(220);
    wait_for_results();

    repeat (Latency + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[vector_angle_by_sine_search] OK");
    end else begin
      $display("[vector_angle_by_sine_search] ERROR");
    end
    $finish;
  end

endmodule
